@@ design/sopa_pkg.sv @@
// ----------------------------------------------------------------------------
// Sublattice order parameter package
// Widths, microcode types and the control program of the order parameter
// accumulator.
// ----------------------------------------------------------------------------
package sopa_pkg;

    localparam int COORD_W = 6;
    localparam int CODE_W  = 2;
    localparam int CNT_W   = 19;
    localparam int SPIN_W  = 20;
    localparam int NUM_W   = 22;
    localparam int MAG_W   = NUM_W - 1;
    localparam int FRAC_W  = 16;
    localparam int QUO_W   = 18;
    localparam int DVD_W   = 38;
    localparam int RES_W   = 16;
    localparam int NCLS    = 4;
    localparam int NSUB    = 4;
    localparam int CLS_W   = 2;
    localparam int DCNT_W  = 5;
    localparam int STEP_W  = 4;

    // Species and spin codes as they appear on the input.
    localparam logic [CODE_W-1:0] SPECIES_POS  = 2'b01;
    localparam logic [CODE_W-1:0] SPECIES_ZERO = 2'b00;
    localparam logic [CODE_W-1:0] SPECIES_NEG  = 2'b11;
    localparam logic [CODE_W-1:0] SPIN_UP      = 2'b01;

    // Result classes.
    localparam logic [CLS_W-1:0] CLS_POS     = 2'd0;
    localparam logic [CLS_W-1:0] CLS_ZERO_UP = 2'd1;
    localparam logic [CLS_W-1:0] CLS_ZERO_DN = 2'd2;
    localparam logic [CLS_W-1:0] CLS_NEG     = 2'd3;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [SPIN_W-1:0] SPIN_MAX = {1'b0, {(SPIN_W-1){1'b1}}};
    localparam logic [SPIN_W-1:0] SPIN_MIN = {1'b1, {(SPIN_W-1){1'b0}}};
    localparam logic [RES_W-1:0]  Q15_MAX  = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0]  Q15_MIN  = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [QUO_W-1:0]  QUO_POS_LIM = QUO_W'(32767);
    localparam logic [QUO_W-1:0]  QUO_NEG_LIM = QUO_W'(32768);
    localparam logic [DCNT_W-1:0] DIV_STEPS_M1 = DCNT_W'(QUO_W - 1);

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        UOP_IDLE,
        UOP_LOAD,
        UOP_DIV,
        UOP_STORE,
        UOP_EMIT,
        UOP_CLEAR
    } uop_t;

    typedef enum logic [1:0] {
        SEL_M,
        SEL_X,
        SEL_Y,
        SEL_Z
    } sel_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_JUMP,
        COND_JUMP_MORE
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        sel_t  sel;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_LOAD_X = 4'd4;
    localparam step_t STEP_CLEAR  = 4'd14;

    // Control program. Idle steps, divide steps and emit steps hold on
    // their own conditions; the cond field only chooses where to go next.
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        case (step)
            4'd0:    w = '{UOP_IDLE,  SEL_M, COND_NEXT,      STEP_IDLE};
            4'd1:    w = '{UOP_LOAD,  SEL_M, COND_NEXT,      STEP_IDLE};
            4'd2:    w = '{UOP_DIV,   SEL_M, COND_NEXT,      STEP_IDLE};
            4'd3:    w = '{UOP_STORE, SEL_M, COND_NEXT,      STEP_IDLE};
            4'd4:    w = '{UOP_LOAD,  SEL_X, COND_NEXT,      STEP_IDLE};
            4'd5:    w = '{UOP_DIV,   SEL_X, COND_NEXT,      STEP_IDLE};
            4'd6:    w = '{UOP_STORE, SEL_X, COND_NEXT,      STEP_IDLE};
            4'd7:    w = '{UOP_LOAD,  SEL_Y, COND_NEXT,      STEP_IDLE};
            4'd8:    w = '{UOP_DIV,   SEL_Y, COND_NEXT,      STEP_IDLE};
            4'd9:    w = '{UOP_STORE, SEL_Y, COND_NEXT,      STEP_IDLE};
            4'd10:   w = '{UOP_LOAD,  SEL_Z, COND_NEXT,      STEP_IDLE};
            4'd11:   w = '{UOP_DIV,   SEL_Z, COND_NEXT,      STEP_IDLE};
            4'd12:   w = '{UOP_STORE, SEL_Z, COND_NEXT,      STEP_IDLE};
            4'd13:   w = '{UOP_EMIT,  SEL_M, COND_JUMP_MORE, STEP_LOAD_X};
            4'd14:   w = '{UOP_CLEAR, SEL_M, COND_JUMP,      STEP_IDLE};
            default: w = '{UOP_CLEAR, SEL_M, COND_JUMP,      STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ design/sublattice_order_parameter_accum.sv @@
// ----------------------------------------------------------------------------
// Sublattice order parameter accumulator
// Counts lattice sites per class and sublattice and reports the X, Y and Z
// order parameters of each class and the mean magnetization in Q1.15 once per measurement.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries one lattice site per beat. While the block is idle it
// takes one site every cycle; each site bumps the spin sum, the site count and,
// if its species code is valid, one of sixteen class counters. A beat with
// s_last_site set closes the measurement and starts the microcoded sequencer,
// and s_ready stays low until the sequencer is done.
// The m_ channel then delivers four beats, one per class 0..3, the fourth with
// m_last_result set. Each result is registered once the divider has produced
// its quotients; the block is ready for the next measurement once the fourth
// result is registered and the state cleared, later if the receiver stalls.
// Thirteen quotients in all pass through the shared 18-step restoring divider:
// one for the magnetization and three per class.
// When m_ready is low, the sequencer waits at its emit step with the result
// held in the output register; nothing is lost or repeated.
// Reset clears the counters, the sums, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module sublattice_order_parameter_accum
    import sopa_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [COORD_W-1:0]       s_site_x,
    input  logic [COORD_W-1:0]       s_site_y,
    input  logic [COORD_W-1:0]       s_site_z,
    input  logic signed [CODE_W-1:0] s_species,
    input  logic signed [CODE_W-1:0] s_spin,
    input  logic                     s_last_site,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CLS_W-1:0]         m_class_index,
    output logic signed [RES_W-1:0]  m_x_order,
    output logic signed [RES_W-1:0]  m_y_order,
    output logic signed [RES_W-1:0]  m_z_order,
    output logic signed [RES_W-1:0]  m_magnetization,
    output logic                     m_last_result
);

    // Sequencer.
    step_t      step_reg, step_next;
    ctrl_word_t cw;

    // Accumulators. Row r of the counter array holds class r; the rows shift
    // toward row zero as each result is sent, which also clears them.
    logic [CNT_W-1:0]  cnt_reg  [NCLS][NSUB];
    logic [CNT_W-1:0]  cnt_next [NCLS][NSUB];
    logic [SPIN_W-1:0] spin_reg, spin_next;
    logic [CNT_W-1:0]  site_reg, site_next;
    logic [CLS_W-1:0]  cls_reg, cls_next;

    // Divider.
    logic              neg_reg, neg_next;
    logic [DVD_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  dsh_reg, dsh_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;

    // Stored results of the current class.
    logic [RES_W-1:0]  res_m_reg, res_x_reg, res_y_reg, res_z_reg;
    logic [RES_W-1:0]  res_value;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [CLS_W-1:0]  m_class_reg;
    logic [RES_W-1:0]  m_x_reg, m_y_reg, m_z_reg, m_m_reg;
    logic              m_last_reg;

    logic accept, start, out_free, emit_fire, hold;
    logic [NSUB-1:0]   sub_hit;
    logic [CLS_W-1:0]  sub_idx;
    logic [CLS_W-1:0]  cls_idx;
    logic              cls_ok;
    logic [SPIN_W:0]   spin_sum;
    logic signed [NUM_W-1:0] e [NSUB];
    logic signed [NUM_W-1:0] num_sel;
    logic [MAG_W-1:0]  num_mag;
    logic [DVD_W:0]    diff;
    logic              cnt_all_zero;

    assign cw        = ucode_rom(step_reg);
    assign s_ready   = (cw.uop == UOP_IDLE);
    assign accept    = s_valid && s_ready;
    assign start     = accept && s_last_site;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = (cw.uop == UOP_EMIT) && out_free;

    // Next step: a step may hold, then it either falls through or jumps.
    always_comb begin
        hold = ((cw.uop == UOP_IDLE) && !start)
            || ((cw.uop == UOP_DIV) && (dcnt_reg != '0))
            || ((cw.uop == UOP_EMIT) && !out_free);
        step_next = STEP_W'(step_reg + 1'b1);
        if (hold) begin
            step_next = step_reg;
        end else begin
            case (cw.cond)
                COND_NEXT:      step_next = STEP_W'(step_reg + 1'b1);
                COND_JUMP:      step_next = cw.target;
                COND_JUMP_MORE: step_next = (cls_reg != CLS_NEG) ? cw.target
                                                                 : STEP_W'(step_reg + 1'b1);
                default:        step_next = STEP_IDLE;
            endcase
        end
    end

    // Site classification. The sublattice parity of x+y+z/2 is the XOR of
    // the low bits of x and y and bit one of z.
    always_comb begin
        sub_idx = {s_site_z[0], s_site_x[0] ^ s_site_y[0] ^ s_site_z[1]};
        cls_ok  = 1'b1;
        cls_idx = CLS_POS;
        case (s_species)
            SPECIES_POS:  cls_idx = CLS_POS;
            SPECIES_ZERO: cls_idx = (s_spin == SPIN_UP) ? CLS_ZERO_UP : CLS_ZERO_DN;
            SPECIES_NEG:  cls_idx = CLS_NEG;
            default:      cls_ok  = 1'b0;
        endcase
        for (int s = 0; s < NSUB; s++) begin
            sub_hit[s] = (sub_idx == CLS_W'(s));
        end
    end

    // Counters, spin sum and site count.
    always_comb begin
        cnt_next  = cnt_reg;
        spin_next = spin_reg;
        site_next = site_reg;
        cls_next  = cls_reg;
        spin_sum  = {spin_reg[SPIN_W-1], spin_reg}
                  + {{(SPIN_W+1-CODE_W){s_spin[CODE_W-1]}}, s_spin};
        if (accept) begin
            for (int r = 0; r < NCLS; r++) begin
                for (int s = 0; s < NSUB; s++) begin
                    if (cls_ok && (cls_idx == CLS_W'(r)) && sub_hit[s]
                        && (cnt_reg[r][s] != CNT_MAX)) begin
                        cnt_next[r][s] = cnt_reg[r][s] + 1'b1;
                    end
                end
            end
            if (spin_sum[SPIN_W] != spin_sum[SPIN_W-1]) begin
                spin_next = spin_sum[SPIN_W] ? SPIN_MIN : SPIN_MAX;
            end else begin
                spin_next = spin_sum[SPIN_W-1:0];
            end
            if (site_reg != CNT_MAX) begin
                site_next = site_reg + 1'b1;
            end
        end
        if (emit_fire) begin
            for (int r = 0; r < NCLS - 1; r++) begin
                cnt_next[r] = cnt_reg[r+1];
            end
            for (int s = 0; s < NSUB; s++) begin
                cnt_next[NCLS-1][s] = '0;
            end
            cls_next = cls_reg + 1'b1;
        end
        if (cw.uop == UOP_CLEAR) begin
            spin_next = '0;
            site_next = '0;
            cls_next  = CLS_POS;
        end
    end

    // Numerator selection from row zero of the counters.
    always_comb begin
        for (int s = 0; s < NSUB; s++) begin
            e[s] = $signed({{(NUM_W-CNT_W){1'b0}}, cnt_reg[0][s]});
        end
        case (cw.sel)
            SEL_M:   num_sel = $signed({{(NUM_W-SPIN_W){spin_reg[SPIN_W-1]}}, spin_reg});
            SEL_X:   num_sel = e[0] + e[1] - e[2] - e[3];
            SEL_Y:   num_sel = (e[0] - e[1]) <<< 1;
            SEL_Z:   num_sel = (e[2] - e[3]) <<< 1;
            default: num_sel = '0;
        endcase
        num_mag = num_sel[NUM_W-1] ? MAG_W'(-num_sel) : MAG_W'(num_sel);
    end

    // Restoring divider: quotient = (mag * 2^16 + N) / (2N), which rounds
    // mag * 2^15 / N to nearest with ties away from zero. Eighteen quotient
    // bits are enough; the top one set means the result saturates.
    always_comb begin
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        dcnt_next = dcnt_reg;
        diff      = {1'b0, rem_reg} - {1'b0, dsh_reg};
        case (cw.uop)
            UOP_LOAD: begin
                neg_next  = num_sel[NUM_W-1];
                rem_next  = DVD_W'({num_mag, {FRAC_W{1'b0}}}) + DVD_W'(site_reg);
                dsh_next  = DVD_W'({site_reg, {QUO_W{1'b0}}});
                quo_next  = '0;
                dcnt_next = DIV_STEPS_M1;
            end
            UOP_DIV: begin
                if (!diff[DVD_W]) begin
                    rem_next = diff[DVD_W-1:0];
                end
                quo_next = {quo_reg[QUO_W-2:0], !diff[DVD_W]};
                dsh_next = dsh_reg >> 1;
                if (dcnt_reg != '0) begin
                    dcnt_next = dcnt_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Sign and saturation of the finished quotient.
    always_comb begin
        if (neg_reg) begin
            res_value = (quo_reg > QUO_NEG_LIM) ? Q15_MIN : RES_W'(~quo_reg[RES_W-1:0] + 1'b1);
        end else begin
            res_value = (quo_reg > QUO_POS_LIM) ? Q15_MAX : quo_reg[RES_W-1:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        cnt_all_zero = 1'b1;
        for (int r = 0; r < NCLS; r++) begin
            for (int s = 0; s < NSUB; s++) begin
                if (cnt_reg[r][s] != '0) begin
                    cnt_all_zero = 1'b0;
                end
            end
        end
    end

    // Control and accumulator state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_IDLE;
            spin_reg    <= '0;
            site_reg    <= '0;
            cls_reg     <= CLS_POS;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int r = 0; r < NCLS; r++) begin
                for (int s = 0; s < NSUB; s++) begin
                    cnt_reg[r][s] <= '0;
                end
            end
        end else begin
            step_reg    <= step_next;
            spin_reg    <= spin_next;
            site_reg    <= site_next;
            cls_reg     <= cls_next;
            dcnt_reg    <= dcnt_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Datapath and output payload.
    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        if (cw.uop == UOP_STORE) begin
            case (cw.sel)
                SEL_M:   res_m_reg <= res_value;
                SEL_X:   res_x_reg <= res_value;
                SEL_Y:   res_y_reg <= res_value;
                SEL_Z:   res_z_reg <= res_value;
                default: res_m_reg <= res_value;
            endcase
        end
        if (emit_fire) begin
            m_class_reg <= cls_reg;
            m_x_reg     <= res_x_reg;
            m_y_reg     <= res_y_reg;
            m_z_reg     <= res_z_reg;
            m_m_reg     <= res_m_reg;
            m_last_reg  <= (cls_reg == CLS_NEG);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_class_index   = m_class_reg;
    assign m_x_order       = $signed(m_x_reg);
    assign m_y_order       = $signed(m_y_reg);
    assign m_z_order       = $signed(m_z_reg);
    assign m_magnetization = $signed(m_m_reg);
    assign m_last_result   = m_last_reg;

    // The divide loop counts down by one per cycle until it leaves.
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.uop == UOP_DIV) && (dcnt_reg != '0) |=> (dcnt_reg == $past(dcnt_reg) - 1'b1))
        else $error("divide step counter out of sequence");

    // The last site is counted before the sequencer starts, so N is never zero.
    a_site_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.uop == UOP_LOAD) |-> (site_reg != '0))
        else $error("divide started with zero site count");

    // Sending the fourth class ends the program.
    a_last_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire && (cls_reg == CLS_NEG) |=> (step_reg == STEP_CLEAR))
        else $error("sequencer did not finish after the fourth result");

    // The counters, site count and spin sum are clear when the sequencer returns to idle.
    a_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.uop == UOP_CLEAR) |=> cnt_all_zero && (site_reg == '0) && (spin_reg == '0))
        else $error("state not cleared after a measurement");

endmodule
